### hdl/lhs_pkg.sv
// shared constants, types and the bucket bound table for the latency histogram
`timescale 1ns / 1ps
`default_nettype none
package lhs_pkg;

    localparam int NUM_BUCKETS = 19;
    localparam int COUNT_WIDTH = 32;
    localparam int LAT_WIDTH   = 32;
    localparam int SUM_WIDTH   = 64;
    localparam int IDX_WIDTH   = 5;
    localparam int SLOT_W      = $clog2(NUM_BUCKETS);
    localparam int BOUND_LEN   = 18;
    localparam int FIFO_DEPTH  = 2;
    localparam int OUT_BITS    = IDX_WIDTH + 5 * 32;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [SUM_WIDTH-1:0] US_PER_MS = 64'd1000;
    localparam logic [SUM_WIDTH-1:0] US_PER_S  = 64'd1000000;
    localparam logic [31:0]          MASK32    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DUMP
    } t_back_state;

    // one queued word: a dump request or a classified sample
    typedef struct packed {
        logic                 dump;
        logic [LAT_WIDTH-1:0] lat;
        logic [SLOT_W-1:0]    slot;
    } t_job;

    // lower bound of a bucket; past the table the bound is unreachable
    function automatic logic [SUM_WIDTH-1:0] lower_bound(input int idx);
        logic [SUM_WIDTH-1:0] b;
        case (idx)
            0:       b = '0;
            1:       b = 64'd10  * US_PER_MS;
            2:       b = 64'd50  * US_PER_MS;
            3:       b = 64'd100 * US_PER_MS;
            4:       b = 64'd200 * US_PER_MS;
            5:       b = 64'd350 * US_PER_MS;
            6:       b = 64'd500 * US_PER_MS;
            7:       b = 64'd750 * US_PER_MS;
            8:       b = 64'd1   * US_PER_S;
            9:       b = 64'd2   * US_PER_S;
            10:      b = 64'd4   * US_PER_S;
            11:      b = 64'd8   * US_PER_S;
            12:      b = 64'd15  * US_PER_S;
            13:      b = 64'd30  * US_PER_S;
            14:      b = 64'd45  * US_PER_S;
            15:      b = 64'd60  * US_PER_S;
            16:      b = 64'd120 * US_PER_S;
            17:      b = 64'd180 * US_PER_S;
            default: b = '1;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

### hdl/lhs_front.sv
// input stage: takes words, drops zero samples, classifies latency into a bucket
`timescale 1ns / 1ps
`default_nettype none
module lhs_front
    import lhs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_mode,
    input  wire logic [LAT_WIDTH-1:0] i_lat,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_job                      o_job
);

    logic        r_valid;
    t_job        r_job;
    t_job        n_job;
    logic [SLOT_W-1:0] slot;

    // bounds ascend, so the last bound met wins
    always_comb begin
        slot = '0;
        for (int i = 1; i < NUM_BUCKETS; i++) begin
            if (64'(i_lat) >= lower_bound(i)) begin
                slot = SLOT_W'(i);
            end
        end
        n_job.dump = i_mode;
        n_job.lat  = i_lat;
        n_job.slot = slot;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            // a zero-latency record leaves no trace
            r_valid <= i_valid && (i_mode || (i_lat != '0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule
`default_nettype wire

### hdl/lhs_fifo.sv
// short job queue between the classifier and the statistics engine
`timescale 1ns / 1ps
`default_nettype none
module lhs_fifo
    import lhs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_job      o_job
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_job             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

### hdl/lhs_div.sv
// bit-serial restoring divider for the average, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module lhs_div
    import lhs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [SUM_WIDTH-1:0]   i_dividend,
    input  wire logic [COUNT_WIDTH-1:0] i_divisor,
    output logic                        o_done,
    output logic [SUM_WIDTH-1:0]        o_quot
);

    localparam int STEP_W = $clog2(SUM_WIDTH);

    logic                     r_busy;
    logic                     r_done;
    logic [STEP_W-1:0]        r_step;
    logic [COUNT_WIDTH-1:0]   r_den;
    logic [COUNT_WIDTH-1:0]   r_rem;
    logic [SUM_WIDTH-1:0]     r_quo;
    logic [COUNT_WIDTH:0]     shifted;
    logic [COUNT_WIDTH+1:0]   diff;
    logic                     qbit;

    always_comb begin
        shifted = {r_rem, r_quo[SUM_WIDTH-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        qbit    = !diff[COUNT_WIDTH+1];
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SUM_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
            r_quo <= {r_quo[SUM_WIDTH-2:0], qbit};
        end
    end

endmodule
`default_nettype wire

### hdl/lhs_back.sv
// statistics engine: bucket counters, count/sum/min/max and the dump sequencer
`timescale 1ns / 1ps
`default_nettype none
module lhs_back
    import lhs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  t_job                       i_job,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [OUT_DATA_W-1:0]      o_data,
    output logic                       o_last
);

    t_back_state            r_state;
    t_back_state            n_state;
    logic [COUNT_WIDTH-1:0] r_cnt [NUM_BUCKETS];
    logic [COUNT_WIDTH-1:0] r_total;
    logic [SUM_WIDTH-1:0]   r_sum;
    logic [LAT_WIDTH-1:0]   r_min;
    logic [LAT_WIDTH-1:0]   r_max;
    logic [31:0]            r_avg;
    logic [SLOT_W-1:0]      r_idx;
    logic                   r_ovalid;
    logic [OUT_DATA_W-1:0]  r_odata;
    logic                   r_olast;

    logic                   take;
    logic                   do_record;
    logic                   div_start;
    logic                   load_out;
    logic                   dump_end;
    logic [SLOT_W-1:0]      addr;
    logic [COUNT_WIDTH-1:0] cur;
    logic [SUM_WIDTH:0]     sum_ext;
    logic                   div_done;
    logic [SUM_WIDTH-1:0]   quot;
    logic [31:0]            rep_total;
    logic [31:0]            rep_min;
    logic [OUT_DATA_W-1:0]  n_odata;

    lhs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_comb begin
        n_state   = r_state;
        take      = 1'b0;
        do_record = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        dump_end  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                take = i_valid;
                if (i_valid) begin
                    if (i_job.dump) begin
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end else begin
                        do_record = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                load_out = !r_ovalid || i_ready;
                if (load_out && (r_idx == SLOT_W'(NUM_BUCKETS - 1))) begin
                    dump_end = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // one read port on the counters, shared by record and dump
    assign addr    = (r_state == ST_IDLE) ? i_job.slot : r_idx;
    assign cur     = r_cnt[addr];
    assign sum_ext = {1'b0, r_sum} + (SUM_WIDTH + 1)'(i_job.lat);

    always_comb begin
        rep_total = (64'(r_total) > 64'(MASK32)) ? MASK32 : 32'(r_total);
        rep_min   = (r_total == '0) ? '0 : r_min;
        n_odata   = '0;
        n_odata[IDX_WIDTH-1:0]                  = IDX_WIDTH'(r_idx);
        n_odata[IDX_WIDTH +: 32]                = 32'(cur);
        n_odata[IDX_WIDTH + 32 +: 32]           = rep_total;
        n_odata[IDX_WIDTH + 64 +: 32]           = rep_min;
        n_odata[IDX_WIDTH + 96 +: 32]           = r_avg;
        n_odata[IDX_WIDTH + 128 +: 32]          = r_max;
    end

    assign o_ready = take;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                r_cnt[i] <= '0;
            end
            r_total  <= '0;
            r_sum    <= '0;
            r_min    <= '1;
            r_max    <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (do_record) begin
                if (cur != '1) begin
                    r_cnt[addr] <= cur + 1'b1;
                end
                if (r_total != '1) begin
                    r_total <= r_total + 1'b1;
                end
                r_sum <= sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];
                if (i_job.lat < r_min) begin
                    r_min <= i_job.lat;
                end
                if (i_job.lat > r_max) begin
                    r_max <= i_job.lat;
                end
            end
            if (div_start) begin
                r_idx <= '0;
            end
            if (load_out) begin
                // each bucket is cleared as it is reported
                r_cnt[addr] <= '0;
                r_idx       <= r_idx + 1'b1;
            end
            if (dump_end) begin
                r_total <= '0;
                r_sum   <= '0;
                r_min   <= '1;
                r_max   <= '0;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && div_done) begin
            if (r_total == '0) begin
                r_avg <= '0;
            end else begin
                r_avg <= (quot > 64'(MASK32)) ? MASK32 : quot[31:0];
            end
        end
        if (load_out) begin
            r_odata <= n_odata;
            r_olast <= dump_end;
        end
    end

endmodule
`default_nettype wire

### hdl/latency_histogram_stats.sv
// top level of the latency histogram with count, min, average and max
//
//  channel   dir  tdata                                       tuser   tlast
//  s_axis    in   latency_us                                  mode    -
//  m_axis    out  bucket_index, bucket_count, sample_count,   -       last
//                 min, avg, max (from bit 0, padded to 168)
//
// a record word sits in the classifier register, then enters the queue and from there
// updates the counters; records flow at one word per cycle while no dump is under way
// a dump holds the back end in the bit-serial divider for the average,
// then sends 19 words, one per cycle when m_axis_tready stays high
// reset clears every counter at once; no sweep is needed afterwards
// a stalled output holds the back end, and the two-entry queue then fills up
`timescale 1ns / 1ps
`default_nettype none
module latency_histogram_stats
    import lhs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [LAT_WIDTH-1:0]  s_axis_tdata,  // latency_us
    input  wire logic                  s_axis_tuser,  // mode
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // bucket_index, bucket_count,
                                                      // sample_count, min, avg, max
    output logic                       m_axis_tlast   // last
);

    logic f_valid;
    logic f_ready;
    t_job f_job;
    logic q_valid;
    logic q_ready;
    t_job q_job;

    lhs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mode  (s_axis_tuser),
        .i_lat   (s_axis_tdata),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_job   (f_job)
    );

    lhs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    lhs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_job   (q_job),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

### hdl/lhs_checker.sv
// port-level checks for the latency histogram, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module lhs_checker
    import lhs_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tlast
);

    logic [IDX_WIDTH-1:0] idx;
    logic [31:0]          cnt;
    logic [31:0]          mn;
    logic [31:0]          avg;
    logic [31:0]          mx;

    assign idx = m_axis_tdata[IDX_WIDTH-1:0];
    assign cnt = m_axis_tdata[IDX_WIDTH + 32 +: 32];
    assign mn  = m_axis_tdata[IDX_WIDTH + 64 +: 32];
    assign avg = m_axis_tdata[IDX_WIDTH + 96 +: 32];
    assign mx  = m_axis_tdata[IDX_WIDTH + 128 +: 32];

    // last word of a dump is exactly the top bucket
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (idx == IDX_WIDTH'(NUM_BUCKETS - 1))))
        else $error("tlast does not match the top bucket");

    // empty statistics report all zeros
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && cnt == '0) |-> (mn == '0 && avg == '0 && mx == '0))
        else $error("empty statistics not reported as zero");

    // with samples the average lies between min and max
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && cnt != '0) |-> (mn <= avg && avg <= mx))
        else $error("min, average and max out of order");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind latency_histogram_stats lhs_checker u_lhs_checker (.*);
`default_nettype wire

### verif/latency_histogram_stats_test.sv
// self-checking stream testbench for the latency histogram with count, min, average and max
`timescale 1ns / 1ps
module latency_histogram_stats_test;
    import lhs_pkg::*;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_DUMP   = 1'b1;
    localparam int   FLOOR_LEN   = 18;
    localparam int   RANDOM_N    = 410;

    // lower bound of each bucket in microseconds; the top bucket is unreachable
    localparam logic [31:0] FLOOR_US [0:FLOOR_LEN-1] = '{
        32'd0, 32'd10_000, 32'd50_000, 32'd100_000, 32'd200_000, 32'd350_000,
        32'd500_000, 32'd750_000, 32'd1_000_000, 32'd2_000_000, 32'd4_000_000,
        32'd8_000_000, 32'd15_000_000, 32'd30_000_000, 32'd45_000_000,
        32'd60_000_000, 32'd120_000_000, 32'd180_000_000
    };

    typedef struct packed {
        logic        mode;
        logic [31:0] lat;
    } sample_word_t;

    typedef struct packed {
        logic [IDX_WIDTH-1:0] idx;
        logic [31:0]          bcount;
        logic [31:0]          samples;
        logic [31:0]          min_lat;
        logic [31:0]          avg_lat;
        logic [31:0]          max_lat;
        logic                 last;
    } bucket_word_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_CHOPPY,
        SINK_THROTTLED
    } sink_pattern_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [LAT_WIDTH-1:0]  s_axis_tdata = '0;   // latency_us
    logic                  s_axis_tuser = 1'b0; // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // bucket_index, bucket_count,
                                                // sample_count, min, avg, max
    logic                  m_axis_tlast;        // last

    latency_histogram_stats uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // histogram shadow
    logic [COUNT_WIDTH-1:0] hist_bins [NUM_BUCKETS];
    logic [COUNT_WIDTH-1:0] hist_samples;
    logic [SUM_WIDTH-1:0]   hist_sum;
    logic [31:0]            hist_min;
    logic [31:0]            hist_max;

    sample_word_t pending_words [$];
    bucket_word_t expected_buckets [$];

    logic          word_taken = 1'b0;
    int            burst_left = 0;
    int            gap_left = 0;
    sink_pattern_t sink_mode = SINK_OPEN;
    int            sink_left = 0;
    int            fail_count = 0;
    int            records_seen = 0;
    int            zero_seen = 0;
    int            dumps_seen = 0;
    int            buckets_checked = 0;

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic clear_histogram();
        foreach (hist_bins[b])
            hist_bins[b] = '0;
        hist_samples = '0;
        hist_sum     = '0;
        hist_min     = MASK32;
        hist_max     = '0;
    endtask

    function automatic int bucket_of(input logic [31:0] lat);
        int slot;
        slot = 0;
        for (int i = 1; i < NUM_BUCKETS; i++) begin
            if (i < FLOOR_LEN && FLOOR_US[i] <= lat)
                slot = i;
        end
        return slot;
    endfunction

    // update the shadow for one accepted word; a dump queues one word per bucket
    task automatic absorb_word(input logic mode, input logic [31:0] lat);
        bucket_word_t         bw;
        logic [SUM_WIDTH-1:0] quot;
        int                   slot;
        if (mode == MODE_RECORD) begin
            records_seen++;
            if (lat == '0) begin
                zero_seen++;
            end else begin
                slot = bucket_of(lat);
                if (hist_bins[slot] != '1)
                    hist_bins[slot] = hist_bins[slot] + 1'b1;
                if (hist_samples != '1)
                    hist_samples = hist_samples + 1'b1;
                if (hist_sum > ({SUM_WIDTH{1'b1}} - SUM_WIDTH'(lat)))
                    hist_sum = '1;
                else
                    hist_sum = hist_sum + SUM_WIDTH'(lat);
                if (lat < hist_min)
                    hist_min = lat;
                if (lat > hist_max)
                    hist_max = lat;
            end
        end else begin
            dumps_seen++;
            quot = (hist_samples == '0) ? '0 : hist_sum / SUM_WIDTH'(hist_samples);
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                bw.idx     = IDX_WIDTH'(b);
                bw.bcount  = hist_bins[b][31:0];
                bw.samples = (hist_samples > COUNT_WIDTH'(MASK32)) ? MASK32
                                                                  : 32'(hist_samples);
                bw.min_lat = (hist_samples == '0) ? '0 : hist_min;
                bw.avg_lat = (quot > SUM_WIDTH'(MASK32)) ? MASK32 : quot[31:0];
                bw.max_lat = hist_max;
                bw.last    = (b == NUM_BUCKETS - 1);
                expected_buckets.push_back(bw);
            end
            clear_histogram();
        end
    endtask

    task automatic push_word(input logic mode, input logic [31:0] lat);
        pending_words.push_back(sample_word_t'{mode: mode, lat: lat});
    endtask

    // mostly bound edges and in-bucket values, with zeros and full-range noise
    function automatic logic [31:0] pick_latency();
        int          sel;
        int          i;
        logic [31:0] hi;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel <= 4) begin
            i = $urandom_range(1, FLOOR_LEN - 1);
            return FLOOR_US[i] - 1 + $urandom_range(0, 2);
        end
        if (sel <= 7) begin
            i  = $urandom_range(0, FLOOR_LEN - 1);
            hi = (i == FLOOR_LEN - 1) ? MASK32 : FLOOR_US[i+1] - 1;
            return $urandom_range(hi, FLOOR_US[i]);
        end
        return $urandom;
    endfunction

    // sender: bursts of words with idle gaps, holding a word until it is taken
    always @(negedge i_clk) begin : feed
        sample_word_t nxt;
        logic         nxt_valid;
        nxt       = '{mode: s_axis_tuser, lat: s_axis_tdata};
        nxt_valid = s_axis_tvalid;
        if (word_taken) begin
            void'(pending_words.pop_front());
            nxt_valid = 1'b0;
        end
        if (i_rst_n && !nxt_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() > 0) begin
                nxt_valid = 1'b1;
                nxt       = pending_words[0];
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt.lat;
        s_axis_tuser  <= nxt.mode;
    end

    // receiver: phases of always-ready, random chop and long stalls
    always @(negedge i_clk) begin : sink
        if (sink_left == 0) begin
            sink_mode = sink_pattern_t'($urandom_range(0, 2));
            sink_left = $urandom_range(8, 80);
        end else begin
            sink_left--;
        end
        case (sink_mode)
            SINK_OPEN:   m_axis_tready <= 1'b1;
            SINK_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
            default:     m_axis_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge i_clk) begin : watch
        bucket_word_t got;
        bucket_word_t want;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
            clear_histogram();
        end else begin
            word_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got.idx     = m_axis_tdata[0 +: IDX_WIDTH];
                got.bcount  = m_axis_tdata[IDX_WIDTH +: 32];
                got.samples = m_axis_tdata[IDX_WIDTH + 32 +: 32];
                got.min_lat = m_axis_tdata[IDX_WIDTH + 64 +: 32];
                got.avg_lat = m_axis_tdata[IDX_WIDTH + 96 +: 32];
                got.max_lat = m_axis_tdata[IDX_WIDTH + 128 +: 32];
                got.last    = m_axis_tlast;
                if (expected_buckets.size() == 0) begin
                    report_failure($sformatf("unexpected word idx=%0d count=%0d",
                                             got.idx, got.bcount));
                end else begin
                    want = expected_buckets.pop_front();
                    buckets_checked++;
                    if (got.idx !== want.idx || got.bcount !== want.bcount ||
                        got.samples !== want.samples || got.min_lat !== want.min_lat ||
                        got.avg_lat !== want.avg_lat || got.max_lat !== want.max_lat ||
                        got.last !== want.last)
                        report_failure($sformatf(
                            {"exp idx=%0d cnt=%0d n=%0d min=%0d avg=%0d max=%0d last=%0b",
                             " | got idx=%0d cnt=%0d n=%0d min=%0d avg=%0d max=%0d last=%0b"},
                            want.idx, want.bcount, want.samples, want.min_lat,
                            want.avg_lat, want.max_lat, want.last,
                            got.idx, got.bcount, got.samples, got.min_lat,
                            got.avg_lat, got.max_lat, got.last));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_word(s_axis_tuser, s_axis_tdata);
        end
    end

    initial begin
        int run_len;
        clear_histogram();

        // empty dump, zero latency, bucket edges, all-ones sample, average truncation
        push_word(MODE_DUMP, '0);
        push_word(MODE_RECORD, 32'd0);
        push_word(MODE_RECORD, 32'd1);
        push_word(MODE_RECORD, 32'd9_999);
        push_word(MODE_RECORD, 32'd10_000);
        push_word(MODE_RECORD, 32'd750_000);
        push_word(MODE_RECORD, 32'd179_999_999);
        push_word(MODE_RECORD, 32'd180_000_000);
        push_word(MODE_RECORD, MASK32);
        push_word(MODE_RECORD, 32'd0);
        push_word(MODE_DUMP, MASK32);
        push_word(MODE_DUMP, '0);
        push_word(MODE_RECORD, MASK32);
        push_word(MODE_DUMP, 32'h5555_AAAA);
        push_word(MODE_RECORD, 32'd5);
        push_word(MODE_RECORD, 32'd5);
        push_word(MODE_RECORD, 32'd6);
        push_word(MODE_DUMP, '0);

        // runs of samples closed by a dump, now and then a second dump right behind
        while (pending_words.size() < RANDOM_N) begin
            run_len = $urandom_range(4, 30);
            repeat (run_len)
                push_word(MODE_RECORD, pick_latency());
            if ($urandom_range(0, 5) == 0)
                push_word(MODE_DUMP, $urandom);
            push_word(MODE_DUMP, $urandom);
        end

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_words.size() > 0 || expected_buckets.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (expected_buckets.size() > 0)
            report_failure($sformatf("%0d bucket words never arrived",
                                     expected_buckets.size()));
        $display("covered %0d samples (%0d of zero latency) and %0d dumps",
                 records_seen, zero_seen, dumps_seen);
        $display("checked %0d bucket words, %0d failures", buckets_checked, fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
